// ===== rtl/dnp3_frame_header_parser_core_macros.svh =====
// Assertion helpers for the DNP3 link header parser.
// Both expect clk and arst_n in scope.
`ifndef DNP3_FRAME_HEADER_PARSER_CORE_MACROS_SVH
`define DNP3_FRAME_HEADER_PARSER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define DFHP_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dfhp assertion failed");
`define DFHP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dfhp assertion failed");
`else
`define DFHP_ASSERT_SAME(label, ante, cons)
`define DFHP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/dfhp_pkg.sv =====
package dfhp_pkg;

	localparam int HEADER_BYTES     = 10;
	localparam int BLOCK_DATA_BYTES = 16;

	localparam logic [15:0] WATCH_PORT_RESET = 16'd20000;
	localparam logic [4:0]  COUNT_MAX        = 5'd31;
	localparam logic [7:0]  START_BYTE0      = 8'h05;
	localparam logic [7:0]  START_BYTE1      = 8'h64;
	localparam logic [7:0]  LEN_MIN          = 8'd5;

	// byte positions within the frame
	localparam logic [4:0] POS_START0    = 5'd0;
	localparam logic [4:0] POS_START1    = 5'd1;
	localparam logic [4:0] POS_LENGTH    = 5'd2;
	localparam logic [4:0] POS_CONTROL   = 5'd3;
	localparam logic [4:0] POS_DEST_LO   = 5'd4;
	localparam logic [4:0] POS_DEST_HI   = 5'd5;
	localparam logic [4:0] POS_SRC_LO    = 5'd6;
	localparam logic [4:0] POS_SRC_HI    = 5'd7;
	localparam logic [4:0] POS_TRANSPORT = 5'd10;
	localparam logic [4:0] POS_APP_CTL   = 5'd11;
	localparam logic [4:0] POS_APP_FUNC  = 5'd12;

	typedef enum logic [2:0] {
		ST_NONE      = 3'd0,
		ST_LINK      = 3'd1,
		ST_MULTI     = 3'd2,
		ST_TRUNC     = 3'd3,
		ST_TRANSPORT = 3'd4,
		ST_APP       = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		CONF_NONE  = 2'd0,
		CONF_START = 2'd1,
		CONF_PORT  = 2'd2
	} conf_t;

	typedef struct packed {
		logic [7:0]  frame_byte;
		logic        frame_end;
		logic [15:0] dest_port;
		logic        over_tcp;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  confidence;
		logic [7:0]  link_control;
		logic        link_function_known;
		logic [15:0] destination;
		logic [15:0] source;
		logic        transport_fir;
		logic        transport_fin;
		logic [5:0]  transport_seq;
		logic [7:0]  appl_ctrl;
		logic [7:0]  appl_func;
		logic        appl_func_known;
	} result_t;

	// captured header state of the frame in progress
	typedef struct packed {
		logic [4:0]  byte_count;
		logic        start_ok;
		logic [7:0]  length_field;
		logic [7:0]  control;
		logic [15:0] dest;
		logic [15:0] source;
		logic [7:0]  transport;
		logic [7:0]  appl_ctrl;
		logic [7:0]  appl_func;
	} frame_t;

	localparam frame_t FRAME_CLEAR = '{
		byte_count:   5'd0,
		start_ok:     1'b1,
		length_field: 8'd0,
		control:      8'd0,
		dest:         16'd0,
		source:       16'd0,
		transport:    8'd0,
		appl_ctrl:    8'd0,
		appl_func:    8'd0
	};

endpackage

// ===== rtl/dfhp_capture.sv =====
module dfhp_capture (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic [7:0]      frame_byte,
	input  logic            frame_end,
	output dfhp_pkg::frame_t frame_next
);
	import dfhp_pkg::*;

	frame_t frame_q;

	// state as it stands once this byte is taken in
	always_comb begin
		frame_next = frame_q;
		case (frame_q.byte_count)
			POS_START0:    if (frame_byte != START_BYTE0) frame_next.start_ok = 1'b0;
			POS_START1:    if (frame_byte != START_BYTE1) frame_next.start_ok = 1'b0;
			POS_LENGTH:    frame_next.length_field = frame_byte;
			POS_CONTROL:   frame_next.control = frame_byte;
			POS_DEST_LO:   frame_next.dest[7:0] = frame_byte;
			POS_DEST_HI:   frame_next.dest[15:8] = frame_byte;
			POS_SRC_LO:    frame_next.source[7:0] = frame_byte;
			POS_SRC_HI:    frame_next.source[15:8] = frame_byte;
			POS_TRANSPORT: frame_next.transport = frame_byte;
			POS_APP_CTL:   frame_next.appl_ctrl = frame_byte;
			POS_APP_FUNC:  frame_next.appl_func = frame_byte;
			default:       ;
		endcase
		if (frame_q.byte_count != COUNT_MAX) begin
			frame_next.byte_count = frame_q.byte_count + 5'd1;
		end
	end

	// drop all per-frame state on the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= FRAME_CLEAR;
		end else if (advance) begin
			frame_q <= frame_end ? FRAME_CLEAR : frame_next;
		end
	end

endmodule

// ===== rtl/dfhp_decide.sv =====
module dfhp_decide #(
	parameter int BLOCK_BYTES = dfhp_pkg::BLOCK_DATA_BYTES
) (
	input  dfhp_pkg::frame_t  frame,
	input  logic              over_tcp,
	input  logic [15:0]       dest_port,
	input  logic [15:0]       watch_port,
	output dfhp_pkg::result_t result
);
	import dfhp_pkg::*;

	function automatic logic link_known(input logic [7:0] ctl);
		logic [3:0] f;
		f = ctl[3:0];
		if (ctl[6]) begin
			return f inside {4'h0, 4'h2, 4'h3, 4'h4, 4'h9};
		end
		return f inside {4'h0, 4'h1, 4'hB, 4'hF};
	endfunction

	function automatic logic app_known(input logic [7:0] fc);
		return fc inside {[8'h01:8'h06], 8'h0D, 8'h0E, 8'h81, 8'h82};
	endfunction

	logic       frame_ok;
	logic [7:0] user_len;
	logic       truncated;
	status_t    status;

	assign frame_ok = over_tcp && (frame.byte_count >= 5'(HEADER_BYTES)) && frame.start_ok
		&& (frame.length_field >= LEN_MIN);
	assign user_len  = frame.length_field - LEN_MIN;
	assign truncated = (9'(HEADER_BYTES) + {1'b0, user_len}) > {4'b0, frame.byte_count};

	always_comb begin
		if (!frame_ok)                                  status = ST_NONE;
		else if (user_len == 8'd0)                      status = ST_LINK;
		else if (user_len > 8'(BLOCK_BYTES))            status = ST_MULTI;
		else if (truncated)                             status = ST_TRUNC;
		else if (user_len < 8'd3)                       status = ST_TRANSPORT;
		else                                            status = ST_APP;
	end

	always_comb begin
		result        = '0;
		result.status = status;
		if (frame_ok) begin
			result.confidence          = (dest_port == watch_port) ? CONF_PORT : CONF_START;
			result.link_control        = frame.control;
			result.link_function_known = link_known(frame.control);
			result.destination         = frame.dest;
			result.source              = frame.source;
		end
		if (status == ST_TRANSPORT || status == ST_APP) begin
			result.transport_fir = frame.transport[7];
			result.transport_fin = frame.transport[6];
			result.transport_seq = frame.transport[5:0];
		end
		if (status == ST_APP) begin
			result.appl_ctrl       = frame.appl_ctrl;
			result.appl_func       = frame.appl_func;
			result.appl_func_known = app_known(frame.appl_func);
		end
	end

endmodule

// ===== rtl/dnp3_frame_header_parser_core.sv =====
// DNP3 link header parser. Takes a TCP payload one byte per beat on the item
// channel, with frame_end on the last byte; dest_port and over_tcp are used
// from that last beat. Each payload yields exactly one result beat, issued
// after its last byte, and no beats otherwise. The block sustains one byte
// per cycle: a beat lands in the stage-1 input register, and from there a
// short compare-and-capture step updates the header state and, on a last
// byte, the grading logic loads the result register. While a result waits for
// result_ready, further bytes keep flowing; only the next frame's last byte
// holds in stage 1 until the result register frees. The start bytes 0x05 0x64,
// length and addresses are checked and decoded; the header CRC is not
// checked. The watched destination port (reset 20000) is written through
// cfg_we/cfg_wdata and must only change while the block is idle.
`include "dnp3_frame_header_parser_core_macros.svh"

module dnp3_frame_header_parser_core #(
	parameter int BLOCK_BYTES = dfhp_pkg::BLOCK_DATA_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata,
	input  logic              item_valid,
	output logic              item_ready,
	input  dfhp_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output dfhp_pkg::result_t result
);
	import dfhp_pkg::*;

	logic [15:0] watch_port_q;
	logic        valid_s1;
	item_t       item_s1;
	logic        advance_s1;
	frame_t      frame_next;
	result_t     result_next;

	// configuration register: written directly, no handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			watch_port_q <= WATCH_PORT_RESET;
		end else if (cfg_we) begin
			watch_port_q <= cfg_wdata;
		end
	end

	// Stage 1 moves on unless it holds a last byte and the result register
	// is still occupied by an untaken result.
	assign advance_s1 = valid_s1 && (!item_s1.frame_end || !result_valid || result_ready);
	assign item_ready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	dfhp_capture u_capture (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance_s1),
		.frame_byte (item_s1.frame_byte),
		.frame_end  (item_s1.frame_end),
		.frame_next (frame_next)
	);

	dfhp_decide #(
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_decide (
		.frame      (frame_next),
		.over_tcp   (item_s1.over_tcp),
		.dest_port  (item_s1.dest_port),
		.watch_port (watch_port_q),
		.result     (result_next)
	);

	// Result register: load on a last byte, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance_s1 && item_s1.frame_end) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && item_s1.frame_end) begin
			result <= result_next;
		end
	end

	`DFHP_ASSERT_NEXT(a_hold_last_byte, valid_s1 && item_s1.frame_end && result_valid && !result_ready, valid_s1 && item_s1.frame_end)
	`DFHP_ASSERT_SAME(a_none_is_zero, result_valid && result.status == ST_NONE, result.confidence == CONF_NONE && result.destination == 16'd0 && result.link_control == 8'd0)
	`DFHP_ASSERT_SAME(a_detect_conf, result_valid && result.status != ST_NONE, result.confidence != CONF_NONE)
	`DFHP_ASSERT_SAME(a_short_no_app, result_valid && result.status != ST_APP, result.appl_func == 8'd0 && result.appl_func_known == 1'b0)

endmodule
